>>> hdl/assert_macros.svh
// assertion macros used by the top-level rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// same-cycle implication, sampled on clk, off while rst_n is low
`define SOD_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sod assertion failed");

// next-cycle implication, sampled on clk, off while rst_n is low
`define SOD_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sod assertion failed");

`else

`define SOD_ASSERT_IMP(lbl, ante, cons)
`define SOD_ASSERT_NXT(lbl, ante, cons)

`endif

`endif

>>> hdl/sod_pkg.sv
// types, register codes and threshold tables for the scaled ordered dither
`default_nettype none

package sod_pkg;

    // configuration register indexes
    typedef enum logic [2:0] {
        REG_MODE_FLAGS      = 3'd0,
        REG_PLANE_COUNT     = 3'd1,
        REG_DEST_BIT_OFFSET = 3'd2,
        REG_SRC_ORIGIN      = 3'd3,
        REG_X_STEP          = 3'd4,
        REG_Y_STEP          = 3'd5,
        REG_CLIP_WINDOW     = 3'd6
    } cfg_reg_t;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 32;

    // mode flag bit positions
    localparam int FLAG_HALFTONE = 0;
    localparam int FLAG_LIGHT    = 1;
    localparam int FLAG_CLEAR    = 2;
    localparam int FLAG_CLIP     = 3;

    localparam int MAX_PLANES = 8;
    localparam int FRAC_BITS  = 16;

    // reset values of the registers
    localparam logic [3:0]  PLANE_COUNT_RST = 4'd4;
    localparam logic [31:0] STEP_RST        = 32'h0001_0000;
    localparam logic [23:0] CLIP_WINDOW_RST = 24'hFFF000;

    // threshold tables, indexed by {row[1:0], column[1:0]}
    localparam logic [3:0] THR_ORDERED [16] = '{
        4'd0, 4'd8, 4'd2, 4'd10, 4'd12, 4'd4, 4'd14, 4'd6,
        4'd3, 4'd11, 4'd1, 4'd9, 4'd14, 4'd7, 4'd13, 4'd5
    };
    localparam logic [3:0] THR_HALFTONE [16] = '{
        4'd5, 4'd12, 4'd14, 4'd3, 4'd8, 4'd0, 4'd6, 4'd10,
        4'd13, 4'd2, 4'd4, 4'd14, 4'd7, 4'd11, 4'd9, 4'd1
    };

    // msb-first bit masks
    localparam logic [7:0] MASK_OF_BIT [8] = '{
        8'd128, 8'd64, 8'd32, 8'd16, 8'd8, 8'd4, 8'd2, 8'd1
    };

    // controls handed to the dither decision
    typedef struct packed {
        logic       halftone;
        logic       light;
        logic       clipped;
        logic [3:0] plane_count;
    } dith_ctrl_t;

endpackage

`default_nettype wire

>>> hdl/sod_if.sv
// valid/ready channel interfaces for pixel items and result items
`default_nettype none

interface sod_pixel_if;
    logic       valid;
    logic       ready;
    logic [7:0] plane_bits;
    logic       row_end;
    logic       frame_end;

    modport source (output valid, output plane_bits, output row_end, output frame_end,
                    input ready);
    modport sink (input valid, input plane_bits, input row_end, input frame_end,
                  output ready);
endinterface

interface sod_result_if;
    logic        valid;
    logic        ready;
    logic [11:0] row_index;
    logic [9:0]  byte_index;
    logic [7:0]  bit_mask;
    logic        clear_bits;
    logic [15:0] next_src_x;
    logic [15:0] next_src_y;
    logic        frame_done;

    modport source (output valid, output row_index, output byte_index, output bit_mask,
                    output clear_bits, output next_src_x, output next_src_y,
                    output frame_done, input ready);
    modport sink (input valid, input row_index, input byte_index, input bit_mask,
                  input clear_bits, input next_src_x, input next_src_y,
                  input frame_done, output ready);
endinterface

`default_nettype wire

>>> hdl/scaled_ordered_dither_top.sv
// top level of the scaled ordered dither: registers, counters, accumulators, result stage
//
//  channel  | direction | handshake       | payload
//  ---------+-----------+-----------------+-----------------------------------------------
//  pixel    | in        | valid / ready   | plane_bits, row_end, frame_end
//  result   | out       | valid / ready   | row_index, byte_index, bit_mask, clear_bits,
//           |           |                 | next_src_x, next_src_y, frame_done
//  cfg      | in        | cfg_we only     | cfg_index, cfg_data
//
//  one item per cycle unless result.ready stalls; each result shows in the next cycle
//  the per-item path is the 32-bit accumulator add and the threshold compare
//  rst_n sets the configuration, walk state and result valid to their reset values;
//  the result payload has no reset and is loaded only when an item is accepted
//  pixel.ready stays high while the result register is empty or being taken,
//  so a waiting result stalls the input only while result.ready is low
`default_nettype none

`include "assert_macros.svh"

module scaled_ordered_dither_top
    import sod_pkg::*;
#(
    parameter int MAX_DEST_WIDTH  = 4096,
    parameter int MAX_DEST_HEIGHT = 4096
)
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   cfg_we,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_data,
    sod_pixel_if.sink                   pixel,
    sod_result_if.source                result
);

    // counter widths follow the destination limits
    localparam int CW  = $clog2(MAX_DEST_WIDTH);
    localparam int RW  = $clog2(MAX_DEST_HEIGHT);
    // position sum wide enough for column plus a 12-bit offset, and for bits 12..3
    localparam int PW  = ((CW > 12) ? CW : 12) + 1;
    localparam int RXW = (RW > 12) ? RW : 12;

    // configuration registers
    logic [3:0]  mode_reg,   mode_next;
    logic [3:0]  planes_reg, planes_next;
    logic [11:0] offset_reg, offset_next;
    logic [31:0] origin_reg, origin_next;
    logic [31:0] xstep_reg,  xstep_next;
    logic [31:0] ystep_reg,  ystep_next;
    logic [23:0] clip_reg,   clip_next;

    // walk state
    logic [CW-1:0] col_reg,  col_next;
    logic [RW-1:0] row_reg,  row_next;
    logic [31:0]   xacc_reg, xacc_next;
    logic [31:0]   yacc_reg, yacc_next;

    // result stage
    logic        res_valid_reg, res_valid_next;
    logic [11:0] row_index_reg;
    logic [9:0]  byte_index_reg;
    logic [7:0]  bit_mask_reg;
    logic        clear_bits_reg;
    logic [15:0] next_x_reg;
    logic [15:0] next_y_reg;
    logic        frame_done_reg;

    logic          accept;
    logic [PW-1:0] pos;
    logic [RXW-1:0] row_ext;
    logic [11:0]   row12;
    logic          clipped;
    dith_ctrl_t    dctrl;
    logic [7:0]    mask;
    logic [31:0]   origin_xacc;
    logic [31:0]   origin_yacc;
    logic [CW:0]   col_plus;
    logic [RW:0]   row_plus;
    logic [CW-1:0] col_wrap;
    logic [RW-1:0] row_wrap;
    logic [CW-1:0] col_item;
    logic [RW-1:0] row_item;
    logic [31:0]   xacc_item;
    logic [31:0]   yacc_item;

    // the result register frees itself when taken, so the input is open then too
    assign pixel.ready = !res_valid_reg || result.ready;
    assign accept      = pixel.valid && pixel.ready;

    // destination placement of the current pixel
    assign pos     = PW'(col_reg) + PW'(offset_reg);
    assign row_ext = RXW'(row_reg);
    assign row12   = row_ext[11:0];
    assign clipped = mode_reg[FLAG_CLIP] &&
                     ((row12 < clip_reg[11:0]) || (row12 > clip_reg[23:12]));

    assign dctrl.halftone    = mode_reg[FLAG_HALFTONE];
    assign dctrl.light       = mode_reg[FLAG_LIGHT];
    assign dctrl.clipped     = clipped;
    assign dctrl.plane_count = planes_reg;

    sod_dither u_dither (
        .plane_bits (pixel.plane_bits),
        .ctrl       (dctrl),
        .col_phase  (col_reg[1:0]),
        .row_phase  (row_reg[1:0]),
        .bit_pos    (pos[2:0]),
        .bit_mask   (mask)
    );

    // accumulators reload to the origin's integer part
    assign origin_xacc = {origin_reg[15:0], 16'h0000};
    assign origin_yacc = {origin_reg[31:16], 16'h0000};

    // counters wrap at the destination limits
    assign col_plus = (CW+1)'(col_reg) + (CW+1)'(1);
    assign row_plus = (RW+1)'(row_reg) + (RW+1)'(1);
    assign col_wrap = (col_plus >= (CW+1)'(MAX_DEST_WIDTH))  ? '0 : col_plus[CW-1:0];
    assign row_wrap = (row_plus >= (RW+1)'(MAX_DEST_HEIGHT)) ? '0 : row_plus[RW-1:0];

    // state after one pixel; frame end wins over row end
    always_comb
    begin
        col_item  = col_reg;
        row_item  = row_reg;
        xacc_item = xacc_reg;
        yacc_item = yacc_reg;
        if (pixel.frame_end)
        begin
            col_item  = '0;
            row_item  = '0;
            xacc_item = origin_xacc;
            yacc_item = origin_yacc;
        end
        else if (pixel.row_end)
        begin
            // y steps once every fourth row
            if (row_reg[1:0] == 2'd3)
            begin
                yacc_item = yacc_reg + ystep_reg;
            end
            col_item  = '0;
            row_item  = row_wrap;
            xacc_item = origin_xacc;
        end
        else
        begin
            // x steps once every fourth column
            if (col_reg[1:0] == 2'd3)
            begin
                xacc_item = xacc_reg + xstep_reg;
            end
            col_item = col_wrap;
        end
    end

    // register writes and walk state update
    always_comb
    begin
        mode_next   = mode_reg;
        planes_next = planes_reg;
        offset_next = offset_reg;
        origin_next = origin_reg;
        xstep_next  = xstep_reg;
        ystep_next  = ystep_reg;
        clip_next   = clip_reg;
        col_next    = col_reg;
        row_next    = row_reg;
        xacc_next   = xacc_reg;
        yacc_next   = yacc_reg;

        if (accept)
        begin
            col_next  = col_item;
            row_next  = row_item;
            xacc_next = xacc_item;
            yacc_next = yacc_item;
        end

        if (cfg_we)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_MODE_FLAGS:      mode_next   = cfg_data[3:0];
                REG_PLANE_COUNT:     planes_next = cfg_data[3:0];
                REG_DEST_BIT_OFFSET: offset_next = cfg_data[11:0];
                REG_SRC_ORIGIN:
                begin
                    // an origin write reloads both accumulators at once
                    origin_next = cfg_data;
                    xacc_next   = {cfg_data[15:0], 16'h0000};
                    yacc_next   = {cfg_data[31:16], 16'h0000};
                end
                REG_X_STEP:          xstep_next  = cfg_data;
                REG_Y_STEP:          ystep_next  = cfg_data;
                REG_CLIP_WINDOW:     clip_next   = cfg_data[23:0];
                default:             ;
            endcase
        end
    end

    assign res_valid_next = accept ? 1'b1 : (result.ready ? 1'b0 : res_valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg      <= '0;
            planes_reg    <= PLANE_COUNT_RST;
            offset_reg    <= '0;
            origin_reg    <= '0;
            xstep_reg     <= STEP_RST;
            ystep_reg     <= STEP_RST;
            clip_reg      <= CLIP_WINDOW_RST;
            col_reg       <= '0;
            row_reg       <= '0;
            xacc_reg      <= '0;
            yacc_reg      <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            mode_reg      <= mode_next;
            planes_reg    <= planes_next;
            offset_reg    <= offset_next;
            origin_reg    <= origin_next;
            xstep_reg     <= xstep_next;
            ystep_reg     <= ystep_next;
            clip_reg      <= clip_next;
            col_reg       <= col_next;
            row_reg       <= row_next;
            xacc_reg      <= xacc_next;
            yacc_reg      <= yacc_next;
            res_valid_reg <= res_valid_next;
        end
    end

    // result payload, loaded with each accepted item
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            row_index_reg  <= row12;
            byte_index_reg <= pos[12:3];
            bit_mask_reg   <= mask;
            clear_bits_reg <= mode_reg[FLAG_CLEAR];
            next_x_reg     <= xacc_item[31:FRAC_BITS];
            next_y_reg     <= yacc_item[31:FRAC_BITS];
            frame_done_reg <= pixel.frame_end;
        end
    end

    assign result.valid      = res_valid_reg;
    assign result.row_index  = row_index_reg;
    assign result.byte_index = byte_index_reg;
    assign result.bit_mask   = bit_mask_reg;
    assign result.clear_bits = clear_bits_reg;
    assign result.next_src_x = next_x_reg;
    assign result.next_src_y = next_y_reg;
    assign result.frame_done = frame_done_reg;

    // a new item is never taken over a result that is still held
    `SOD_ASSERT_IMP(a_no_overwrite, accept, !res_valid_reg || result.ready)

    // a frame end leaves the walk at the top-left corner
    `SOD_ASSERT_NXT(a_frame_restart, accept && pixel.frame_end, col_reg == '0 && row_reg == '0)

    // a row or frame end reloads x from the origin
    `SOD_ASSERT_NXT(a_row_reload, accept && (pixel.row_end || pixel.frame_end),
                    xacc_reg == {origin_reg[15:0], 16'h0000})

    // clipped rows never carry a mask
    `SOD_ASSERT_IMP(a_clip_mask, result.valid && mode_reg[FLAG_CLIP] &&
                    ((result.row_index < clip_reg[11:0]) || (result.row_index > clip_reg[23:12])),
                    result.bit_mask == 8'd0)

endmodule

`default_nettype wire

>>> hdl/sod_dither.sv
// level build, threshold compare and bit mask for one pixel
`default_nettype none

module sod_dither
    import sod_pkg::*;
(
    input  wire logic [7:0] plane_bits,
    input  wire dith_ctrl_t ctrl,
    input  wire logic [1:0] col_phase,
    input  wire logic [1:0] row_phase,
    input  wire logic [2:0] bit_pos,
    output logic [7:0]      bit_mask
);

    logic [3:0] plane_lim;
    logic [3:0] level_raw;
    logic [3:0] level;
    logic [3:0] thr;

    // last four planes end up top aligned
    always_comb
    begin
        plane_lim = (ctrl.plane_count > 4'(MAX_PLANES)) ? 4'(MAX_PLANES) : ctrl.plane_count;
        level_raw = '0;
        for (int i = 0; i < MAX_PLANES; i++)
        begin
            if (4'(i) < plane_lim)
            begin
                level_raw = {plane_bits[i], level_raw[3:1]};
            end
        end
    end

    assign level = ctrl.light ? (level_raw >> 1) : level_raw;
    assign thr   = ctrl.halftone ? THR_HALFTONE[{row_phase, col_phase}]
                                 : THR_ORDERED[{row_phase, col_phase}];

    assign bit_mask = ((thr < level) && !ctrl.clipped) ? MASK_OF_BIT[bit_pos] : 8'd0;

endmodule

`default_nettype wire

>>> tb/sv/scaled_ordered_dither_top_tb.sv
// self-checking testbench for the scaled ordered dither: predicted results against the block
`timescale 1ns / 1ps

module scaled_ordered_dither_top_tb
    import sod_pkg::*;
();

    // counters wrap here, as in the block's default parameters
    localparam int DEST_WIDTH_LIMIT  = 4096;
    localparam int DEST_HEIGHT_LIMIT = 4096;
    localparam int RANDOM_BUDGET     = 1300;
    localparam int LONG_RUN          = 4100;

    // threshold tables written out here so a wrong package table shows up
    localparam logic [3:0] ORDERED_LEVELS [16] = '{
        4'd0, 4'd8, 4'd2, 4'd10, 4'd12, 4'd4, 4'd14, 4'd6,
        4'd3, 4'd11, 4'd1, 4'd9, 4'd14, 4'd7, 4'd13, 4'd5
    };
    localparam logic [3:0] HALFTONE_LEVELS [16] = '{
        4'd5, 4'd12, 4'd14, 4'd3, 4'd8, 4'd0, 4'd6, 4'd10,
        4'd13, 4'd2, 4'd4, 4'd14, 4'd7, 4'd11, 4'd9, 4'd1
    };

    typedef struct packed {
        logic [11:0] row_index;
        logic [9:0]  byte_index;
        logic [7:0]  bit_mask;
        logic        clear_bits;
        logic [15:0] next_src_x;
        logic [15:0] next_src_y;
        logic        frame_done;
    } raster_write_t;

    // predicts each raster write and keeps the writes still owed by the block
    class dither_scoreboard;
        logic [3:0]    mode;
        logic [3:0]    planes;
        logic [11:0]   bit_offset;
        logic [31:0]   origin;
        logic [31:0]   step_x;
        logic [31:0]   step_y;
        logic [23:0]   clip;
        int            column;
        int            row;
        logic [31:0]   acc_x;
        logic [31:0]   acc_y;
        raster_write_t owed_writes [$];
        int            fails;

        function new();
            mode       = 4'd0;
            planes     = PLANE_COUNT_RST;
            bit_offset = 12'd0;
            origin     = 32'd0;
            step_x     = STEP_RST;
            step_y     = STEP_RST;
            clip       = CLIP_WINDOW_RST;
            column     = 0;
            row        = 0;
            acc_x      = 32'd0;
            acc_y      = 32'd0;
            fails      = 0;
        endfunction

        function void set_reg(cfg_reg_t idx, logic [31:0] value);
            case (idx)
                REG_MODE_FLAGS:      mode = value[3:0];
                REG_PLANE_COUNT:     planes = value[3:0];
                REG_DEST_BIT_OFFSET: bit_offset = value[11:0];
                REG_SRC_ORIGIN:
                begin
                    // origin write reloads both accumulators at once
                    origin = value;
                    acc_x  = {origin[15:0], 16'd0};
                    acc_y  = {origin[31:16], 16'd0};
                end
                REG_X_STEP:          step_x = value;
                REG_Y_STEP:          step_y = value;
                REG_CLIP_WINDOW:     clip = value[23:0];
                default: ;
            endcase
        endfunction

        function void note_pixel(logic [7:0] bits, logic row_end, logic frame_end);
            raster_write_t w;
            logic [3:0]    level;
            logic [3:0]    thr;
            logic [3:0]    cell_idx;
            logic [12:0]   pos;
            logic [11:0]   row12;
            logic          clipped;
            int            used;
            used = (planes > MAX_PLANES) ? MAX_PLANES : planes;
            level = 4'd0;
            // last four planes end up top aligned
            for (int i = 0; i < used; i++)
            begin
                level = level >> 1;
                if (bits[i])
                    level[3] = 1'b1;
            end
            if (mode[FLAG_LIGHT])
                level = level >> 1;
            cell_idx = {row[1:0], column[1:0]};
            thr = mode[FLAG_HALFTONE] ? HALFTONE_LEVELS[cell_idx] : ORDERED_LEVELS[cell_idx];
            pos = 13'(column) + 13'(bit_offset);
            row12 = row[11:0];
            clipped = mode[FLAG_CLIP] && (row12 < clip[11:0] || row12 > clip[23:12]);
            w.row_index  = row12;
            w.byte_index = pos[12:3];
            w.bit_mask   = (thr < level && !clipped) ? (8'h80 >> pos[2:0]) : 8'h00;
            w.clear_bits = mode[FLAG_CLEAR];
            if (frame_end)
            begin
                column = 0;
                row    = 0;
                acc_x  = {origin[15:0], 16'd0};
                acc_y  = {origin[31:16], 16'd0};
            end
            else if (row_end)
            begin
                if (row[1:0] == 2'd3)
                    acc_y = acc_y + step_y;
                column = 0;
                row    = (row + 1 >= DEST_HEIGHT_LIMIT) ? 0 : row + 1;
                acc_x  = {origin[15:0], 16'd0};
            end
            else
            begin
                if (column[1:0] == 2'd3)
                    acc_x = acc_x + step_x;
                column = (column + 1 >= DEST_WIDTH_LIMIT) ? 0 : column + 1;
            end
            w.next_src_x = acc_x[31:16];
            w.next_src_y = acc_y[31:16];
            w.frame_done = frame_end;
            owed_writes.push_back(w);
        endfunction

        function void compare_field(string name, logic [31:0] exp_v, logic [31:0] got_v);
            if (exp_v !== got_v)
            begin
                $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, exp_v, got_v);
                fails++;
            end
        endfunction

        function void check_result(raster_write_t got);
            raster_write_t exp_w;
            if (owed_writes.size() == 0)
            begin
                $display("%0t: result with none expected, got %0h", $time, got);
                fails++;
            end
            else
            begin
                exp_w = owed_writes.pop_front();
                compare_field("row_index", exp_w.row_index, got.row_index);
                compare_field("byte_index", exp_w.byte_index, got.byte_index);
                compare_field("bit_mask", exp_w.bit_mask, got.bit_mask);
                compare_field("clear_bits", exp_w.clear_bits, got.clear_bits);
                compare_field("next_src_x", exp_w.next_src_x, got.next_src_x);
                compare_field("next_src_y", exp_w.next_src_y, got.next_src_y);
                compare_field("frame_done", exp_w.frame_done, got.frame_done);
            end
        endfunction

        function int pending();
            return owed_writes.size();
        endfunction
    endclass

    logic                   clk;
    logic                   rst_n;
    logic                   cfg_we;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;

    sod_pixel_if  pixel_ch ();
    sod_result_if result_ch ();

    dither_scoreboard sb = new();

    // idling odds in percent, changed per phase
    int send_idle_pct;
    int recv_stall_pct;
    int items_sent;
    int overflow_items;
    int phase;

    scaled_ordered_dither_top DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .pixel     (pixel_ch),
        .result    (result_ch)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // generous fixed limit, far beyond the slowest correct run
    initial
    begin
        #24_000_000;
        $display("*** FAILED ***");
        $finish;
    end

    // receiver: stalls at random per phase, redrawn every cycle
    always @(posedge clk)
    begin
        if (rst_n)
            result_ch.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    // monitor: both handshakes sampled at the edge, before any update of the step
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (result_ch.valid && result_ch.ready)
                sb.check_result('{result_ch.row_index, result_ch.byte_index,
                                  result_ch.bit_mask, result_ch.clear_bits,
                                  result_ch.next_src_x, result_ch.next_src_y,
                                  result_ch.frame_done});
            if (pixel_ch.valid && pixel_ch.ready)
                sb.note_pixel(pixel_ch.plane_bits, pixel_ch.row_end, pixel_ch.frame_end);
        end
    end

    // one item offered after random idle cycles, held until taken
    task automatic send_pixel(input logic [7:0] bits, input logic row_end, input logic frame_end);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            pixel_ch.valid <= 1'b0;
            @(posedge clk);
        end
        pixel_ch.valid      <= 1'b1;
        pixel_ch.plane_bits <= bits;
        pixel_ch.row_end    <= row_end;
        pixel_ch.frame_end  <= frame_end;
        do
            @(posedge clk);
        while (!pixel_ch.ready);
        items_sent++;
    endtask

    // lowers valid and waits for every owed write plus a little slack
    task automatic drain();
        pixel_ch.valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // write enable stays high across a batch; the caller lowers it
    task automatic write_reg(input cfg_reg_t idx, input logic [31:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        sb.set_reg(idx, value);
        @(posedge clk);
    endtask

    task automatic program_regs(input logic [3:0] mode_v, input logic [3:0] planes_v,
                                input logic [11:0] offset_v, input logic [31:0] origin_v,
                                input logic [31:0] step_x_v, input logic [31:0] step_y_v,
                                input logic [23:0] clip_v);
        write_reg(REG_MODE_FLAGS, {28'd0, mode_v});
        write_reg(REG_PLANE_COUNT, {28'd0, planes_v});
        write_reg(REG_DEST_BIT_OFFSET, {20'd0, offset_v});
        write_reg(REG_SRC_ORIGIN, origin_v);
        write_reg(REG_X_STEP, step_x_v);
        write_reg(REG_Y_STEP, step_y_v);
        write_reg(REG_CLIP_WINDOW, {8'd0, clip_v});
        cfg_we <= 1'b0;
    endtask

    // each register drawn from its extremes or from the range between
    task automatic program_random();
        logic [3:0]  mode_v;
        logic [3:0]  planes_v;
        logic [11:0] offset_v;
        logic [31:0] origin_v;
        logic [31:0] step_v [2];
        logic [23:0] clip_v;
        mode_v = 4'($urandom_range(0, 15));
        case ($urandom_range(0, 3))
            0:       planes_v = 4'd0;
            1:       planes_v = 4'd15;
            default: planes_v = 4'($urandom_range(1, 8));
        endcase
        case ($urandom_range(0, 3))
            0:       offset_v = 12'd0;
            1:       offset_v = 12'hFFF;
            default: offset_v = 12'($urandom);
        endcase
        case ($urandom_range(0, 3))
            0:       origin_v = 32'd0;
            1:       origin_v = 32'hFFFF_FFFF;
            default: origin_v = $urandom;
        endcase
        for (int i = 0; i < 2; i++)
        begin
            case ($urandom_range(0, 4))
                0:       step_v[i] = 32'd0;
                1:       step_v[i] = 32'hFFFF_FFFF;
                2:       step_v[i] = $urandom;
                default: step_v[i] = $urandom_range(0, 32'h0003_0000);
            endcase
        end
        // small windows so that the short frames used here hit both edges
        case ($urandom_range(0, 4))
            0:       clip_v = 24'hFFF000;
            1:       clip_v = 24'h000FFF;
            2:       clip_v = 24'($urandom);
            default: clip_v = {12'($urandom_range(0, 12)), 12'($urandom_range(0, 6))};
        endcase
        program_regs(mode_v, planes_v, offset_v, origin_v, step_v[0], step_v[1], clip_v);
    endtask

    // well-formed rows of random length; close ends the frame on the last item
    task automatic send_frame(input int rows, input int max_len, input bit close);
        int   len;
        logic fe;
        logic re;
        for (int r = 0; r < rows; r++)
        begin
            len = $urandom_range(1, max_len);
            for (int c = 0; c < len; c++)
            begin
                fe = close && (r == rows - 1) && (c == len - 1);
                // frame end comes with or without a row end
                re = (c == len - 1) && (!fe || $urandom_range(0, 1));
                send_pixel(8'($urandom), re, fe);
            end
        end
    endtask

    task automatic send_noise(input int count);
        for (int i = 0; i < count; i++)
            send_pixel(8'($urandom), ($urandom_range(0, 3) == 0), ($urandom_range(0, 11) == 0));
    endtask

    // column wrap on one long row, then row wrap on single-item rows
    task automatic overflow_run();
        int start_count;
        start_count = items_sent;
        program_regs({1'b1, 3'($urandom_range(0, 7))}, 4'd8, 12'hFFF, $urandom,
                     $urandom, $urandom, {12'hFFF, 12'hF00});
        for (int c = 0; c < LONG_RUN; c++)
            send_pixel(8'($urandom), (c == LONG_RUN - 1), 1'b0);
        for (int r = 0; r < LONG_RUN; r++)
            send_pixel(8'($urandom), 1'b1, 1'b0);
        send_pixel(8'hFF, 1'b1, 1'b1);
        overflow_items = overflow_items + items_sent - start_count;
    endtask

    initial
    begin
        rst_n               = 1'b0;
        cfg_we              = 1'b0;
        cfg_index           = '0;
        cfg_data            = '0;
        pixel_ch.valid      = 1'b0;
        pixel_ch.plane_bits = 8'd0;
        pixel_ch.row_end    = 1'b0;
        pixel_ch.frame_end  = 1'b0;
        result_ch.ready     = 1'b0;
        send_idle_pct       = 0;
        recv_stall_pct      = 0;
        items_sent          = 0;
        overflow_items      = 0;
        phase               = 0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: reset settings, every threshold cell of the first two rows,
        // level extremes and both kinds of frame end
        send_pixel(8'h00, 1'b0, 1'b0);
        send_pixel(8'hFF, 1'b0, 1'b0);
        send_pixel(8'h0F, 1'b0, 1'b0);
        send_pixel(8'h08, 1'b1, 1'b0);
        send_pixel(8'h0A, 1'b0, 1'b0);
        send_pixel(8'h05, 1'b0, 1'b0);
        send_pixel(8'hFF, 1'b0, 1'b0);
        send_pixel(8'h0C, 1'b1, 1'b0);
        send_pixel(8'h03, 1'b0, 1'b0);
        send_pixel(8'hF0, 1'b1, 1'b0);
        send_pixel(8'h0E, 1'b0, 1'b0);
        send_pixel(8'h07, 1'b0, 1'b1);
        send_pixel(8'hFF, 1'b1, 1'b1);
        send_pixel(8'h0F, 1'b0, 1'b1);
        drain();

        // phases: settings change only here, with the block drained
        while (phase < 6 || items_sent - overflow_items < RANDOM_BUDGET)
        begin
            case (phase % 4)
                0:
                begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 0;
                end
                1:
                begin
                    send_idle_pct  = 75;
                    recv_stall_pct = 0;
                end
                2:
                begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 75;
                end
                default:
                begin
                    send_idle_pct  = 13;
                    recv_stall_pct = 13;
                end
            endcase
            case (phase)
                // all extremes high, zero planes, empty clip window
                0: program_regs(4'hF, 4'd0, 12'hFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                                32'hFFFF_FFFF, 24'h000FFF);
                // clipping only, planes above the maximum, steps of zero
                1: program_regs(4'h8, 4'd15, 12'd0, 32'd0, 32'd0, 32'd0, 24'h005002);
                // full eight planes, halftone light, unit steps
                2: program_regs(4'h3, 4'd8, 12'd3, 32'h0002_0005, STEP_RST, STEP_RST,
                                CLIP_WINDOW_RST);
                default: program_random();
            endcase
            if (phase == 5)
            begin
                send_idle_pct  = 13;
                recv_stall_pct = 13;
                overflow_run();
            end
            else
            begin
                repeat ($urandom_range(1, 3))
                    send_frame($urandom_range(1, 8), $urandom_range(1, 24), 1'b1);
                if ($urandom_range(0, 2) == 0)
                    send_noise($urandom_range(1, 16));
                // sometimes leave the frame open so the next origin write lands mid-frame
                if ($urandom_range(0, 1) == 0)
                    send_frame($urandom_range(1, 3), $urandom_range(1, 12), 1'b0);
            end
            drain();
            phase++;
        end

        repeat (8) @(posedge clk);
        if (sb.fails == 0 && sb.pending() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

>>> files.f
+incdir+hdl
hdl/sod_pkg.sv
hdl/sod_if.sv
hdl/sod_dither.sv
hdl/scaled_ordered_dither_top.sv
tb/sv/scaled_ordered_dither_top_tb.sv
